>>> rtl/nvse_pkg.sv
// Shared constants for the nearest vector search engine.
`default_nettype none

package nvse_pkg;

    localparam int KIND_W   = 2;
    localparam int ENT_IN_W = 8;
    localparam int ELT_W    = 9;
    localparam int VAL_W    = 16;
    localparam int DIM_W    = 10;
    localparam int STATUS_W = 2;
    localparam int DIST_W   = 18;
    localparam int ACC_W    = 40;
    localparam int PROD_W   = 2 * VAL_W;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENABLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [DIM_W-1:0]  DIM_RESET = 10'd128;
    localparam logic [DIM_W-1:0]  COUNT_MAX = 10'd1023;
    localparam logic [DIST_W-1:0] DIST_MAX  = 18'h3ffff;

endpackage

`default_nettype wire

>>> rtl/nearest_vector_search_engine_core.sv
// Nearest vector search engine: exhaustive dot-product search over a vector table.
//
//   channel  | direction | ports                                   | handshake
//   ---------+-----------+-----------------------------------------+-----------------
//   s_       | in        | kind, indices, element value, flags     | s_valid/s_ready
//   m_       | out       | status, best index, score, distance     | m_valid/m_ready
//   cfg_     | in        | dim_in_use                              | cfg_valid/cfg_ready
//
// Entry write and enable beats are taken while idle. A query element within range
// walks every entry through one shared 16x16 multiplier and 40-bit adder, one entry
// per cycle, via the store and accumulator RAM ports. After the last element a max
// search over enabled entries runs unless the count mismatches, then the rounding.
// s_ready is low while a beat is in work and while a result cannot enter m_.
// Synchronous active-low reset; accumulators are cleared by valid bits, no sweep.
`default_nettype none

module nearest_vector_search_engine_core import nvse_pkg::*; #(
    parameter int NUM_ENTRIES = 256,
    parameter int DIM_MAX     = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [KIND_W-1:0]        s_kind,
    input  wire logic [ENT_IN_W-1:0]      s_entry_index,
    input  wire logic [ELT_W-1:0]         s_element_index,
    input  wire logic signed [VAL_W-1:0]  s_element_value,
    input  wire logic                     s_enable_flag,
    input  wire logic                     s_last_element,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [STATUS_W-1:0]           m_status,
    output logic [ENT_IN_W-1:0]           m_best_index,
    output logic signed [VAL_W-1:0]       m_score,
    output logic [DIST_W-1:0]             m_distance_squared,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [DIM_W-1:0]         cfg_dim_in_use
);

    localparam int ENT_W    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int SDEPTH   = NUM_ENTRIES * DIM_MAX;
    localparam int SADDR_W  = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam logic [ENT_W-1:0]   LAST_ENT = ENT_W'(NUM_ENTRIES - 1);
    localparam logic [SADDR_W-1:0] ROW_STEP = SADDR_W'(DIM_MAX);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MAC    = 7'b0000010,
        ST_MDRAIN = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_SDRAIN = 7'b0010000,
        ST_CALC   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [DIM_W-1:0]          dim_reg;
    logic [DIM_W-1:0]          count_reg;
    logic [NUM_ENTRIES-1:0]    enabled_reg;
    logic [NUM_ENTRIES-1:0]    acc_vld_reg;
    logic [ENT_W-1:0]          i_reg;
    logic [SADDR_W-1:0]        base_reg;
    logic [ELT_W-1:0]          elt_reg;
    logic signed [VAL_W-1:0]   val_reg;
    logic                      last_reg;
    logic                      mism_reg;
    logic                      p1_mac_reg, p1_scan_reg;
    logic [ENT_W-1:0]          p1_idx_reg;
    logic                      p2_vld_reg;
    logic [ENT_W-1:0]          p2_idx_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   accv_reg;
    logic signed [ACC_W-1:0]   top_reg;
    logic [ENT_W-1:0]          best_reg;
    logic                      found_reg;
    logic signed [ACC_W:0]     sc_sum_reg;
    logic signed [ACC_W+1:0]   d_reg;
    logic                      m_valid_reg;
    logic [STATUS_W-1:0]       m_status_reg;
    logic [ENT_IN_W-1:0]       m_best_reg;
    logic signed [VAL_W-1:0]   m_score_reg;
    logic [DIST_W-1:0]         m_dist_reg;

    logic                      s_fire;
    logic                      out_free;
    logic                      ent_ok, elt_ok, mac_en;
    logic [DIM_W-1:0]          count_next;
    logic                      mism_next;
    logic                      store_we;
    logic [SADDR_W-1:0]        store_waddr;
    logic [VAL_W-1:0]          store_rdata;
    logic [ACC_W-1:0]          acc_rdata;
    logic signed [ACC_W-1:0]   acc_cur;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W:0]     sc_q;
    logic signed [ACC_W+1:0]   d_round;
    logic signed [VAL_W-1:0]   score_sat;
    logic [DIST_W-1:0]         dist_sat;
    logic [STATUS_W-1:0]       status_fin;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign ent_ok     = 32'(s_entry_index) < NUM_ENTRIES;
    assign elt_ok     = 32'(s_element_index) < DIM_MAX;
    assign mac_en     = elt_ok && ({1'b0, s_element_index} < dim_reg);
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign mism_next  = (count_next != dim_reg);

    assign store_we    = s_fire && (s_kind == KIND_WRITE) && ent_ok && elt_ok;
    assign store_waddr = SADDR_W'(32'(s_entry_index) * DIM_MAX + 32'(s_element_index));

    nvse_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SDEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (s_element_value),
        .raddr (base_reg + SADDR_W'(elt_reg)),
        .rdata (store_rdata)
    );

    nvse_ram #(
        .WIDTH (ACC_W),
        .DEPTH (NUM_ENTRIES)
    ) u_acc (
        .aclk  (aclk),
        .we    (p2_vld_reg),
        .waddr (p2_idx_reg),
        .wdata (acc_sum),
        .raddr (i_reg),
        .rdata (acc_rdata)
    );

    // unwritten accumulators read as zero
    assign acc_cur = acc_vld_reg[p1_idx_reg] ? $signed(acc_rdata) : '0;
    assign acc_sum = accv_reg + ACC_W'(prod_reg);

    always_comb begin
        sc_q    = sc_sum_reg >>> 15;
        d_round = (d_reg + 42'sd16384) >>> 15;
        if (sc_q > 41'sd32767) begin
            score_sat = 16'sh7fff;
        end else if (sc_q < -41'sd32768) begin
            score_sat = -16'sh8000;
        end else begin
            score_sat = VAL_W'(sc_q);
        end
        if (d_reg <= 42'sd0) begin
            dist_sat = '0;
        end else if (d_round > 42'sd262143) begin
            dist_sat = DIST_MAX;
        end else begin
            dist_sat = DIST_W'(d_round);
        end
        if (mism_reg) begin
            status_fin = STATUS_MISMATCH;
        end else if (!found_reg) begin
            status_fin = STATUS_EMPTY;
        end else begin
            status_fin = STATUS_MATCH;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_kind == KIND_QUERY)) begin
                    if (mac_en) begin
                        state_next = ST_MAC;
                    end else if (!s_last_element) begin
                        state_next = ST_IDLE;
                    end else if (mism_next) begin
                        state_next = ST_CALC;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_MAC: begin
                if (i_reg == LAST_ENT) begin
                    state_next = ST_MDRAIN;
                end
            end
            ST_MDRAIN: begin
                if (!p1_mac_reg && !p2_vld_reg) begin
                    if (!last_reg) begin
                        state_next = ST_IDLE;
                    end else if (mism_reg) begin
                        state_next = ST_CALC;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_reg == LAST_ENT) begin
                    state_next = ST_SDRAIN;
                end
            end
            ST_SDRAIN: begin
                if (!p1_scan_reg) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        // datapath, no reset
        prod_reg   <= val_reg * $signed(store_rdata);
        accv_reg   <= acc_cur;
        p1_idx_reg <= i_reg;
        p2_idx_reg <= p1_idx_reg;

        if (s_fire && (s_kind == KIND_QUERY)) begin
            elt_reg  <= s_element_index;
            val_reg  <= s_element_value;
            last_reg <= s_last_element;
            mism_reg <= mism_next;
        end

        if ((state_reg == ST_MAC) || (state_reg == ST_SCAN)) begin
            i_reg    <= i_reg + 1'b1;
            base_reg <= base_reg + ROW_STEP;
        end else begin
            i_reg    <= '0;
            base_reg <= '0;
        end

        if (p1_scan_reg && enabled_reg[p1_idx_reg] && (!found_reg || acc_cur > top_reg)) begin
            top_reg  <= acc_cur;
            best_reg <= p1_idx_reg;
        end

        if (state_reg == ST_CALC) begin
            sc_sum_reg <= (ACC_W + 1)'(top_reg) + 41'sd16384;
            d_reg      <= 42'sd2147483648 - ((ACC_W + 2)'(top_reg) <<< 1);
        end

        if ((state_reg == ST_DONE) && out_free) begin
            m_status_reg <= status_fin;
            m_best_reg   <= (status_fin == STATUS_MATCH) ? ENT_IN_W'(best_reg) : '0;
            m_score_reg  <= (status_fin == STATUS_MATCH) ? score_sat : '0;
            m_dist_reg   <= (status_fin == STATUS_MATCH) ? dist_sat : '0;
        end

        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dim_reg     <= DIM_RESET;
            count_reg   <= '0;
            enabled_reg <= '0;
            acc_vld_reg <= '0;
            p1_mac_reg  <= 1'b0;
            p1_scan_reg <= 1'b0;
            p2_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p1_mac_reg  <= (state_reg == ST_MAC);
            p1_scan_reg <= (state_reg == ST_SCAN);
            p2_vld_reg  <= p1_mac_reg;

            if (cfg_valid && cfg_ready) begin
                dim_reg <= cfg_dim_in_use;
            end

            if (s_fire && (s_kind == KIND_ENABLE) && ent_ok) begin
                enabled_reg[ENT_W'(s_entry_index)] <= s_enable_flag;
            end

            if (s_fire && (s_kind == KIND_QUERY)) begin
                count_reg <= count_next;
                found_reg <= 1'b0;
            end

            if (p2_vld_reg) begin
                acc_vld_reg[p2_idx_reg] <= 1'b1;
            end

            if (p1_scan_reg && enabled_reg[p1_idx_reg]) begin
                found_reg <= 1'b1;
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
                acc_vld_reg <= '0;
                count_reg   <= '0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_best_index       = m_best_reg;
    assign m_score            = m_score_reg;
    assign m_distance_squared = m_dist_reg;

endmodule

`default_nettype wire

>>> rtl/nvse_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
`default_nettype none

module nvse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> verif/tb_nearest_vector_search_engine_core.sv
// Self-checking testbench for the nearest vector search engine core.
`timescale 1ns / 1ps

module tb_nearest_vector_search_engine_core;
    import nvse_pkg::*;

    localparam int ENTRY_COUNT   = 256;
    localparam int SETTLE_CYCLES = 600;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 140;
    localparam int OVERFLOW_LEN  = 1030;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // element positions written in every entry, so every query read is defined
    localparam int SAFE_ELTS [16] = '{0, 1, 2, 3, 4, 5, 6, 7,
                                      127, 170, 255, 256, 341, 384, 510, 511};
    localparam int PHASE_DIMS [RANDOM_PHASES] = '{4, 1, 511, 8, 3, 16, 2, 0};

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [ENT_IN_W-1:0]     entry_index;
        logic [ELT_W-1:0]        element_index;
        logic signed [VAL_W-1:0] element_value;
        logic                    enable_flag;
        logic                    last_element;
    } vec_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [ENT_IN_W-1:0]     best_index;
        logic signed [VAL_W-1:0] score;
        logic [DIST_W-1:0]       distance_squared;
    } search_report_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [KIND_W-1:0]       s_kind = '0;
    logic [ENT_IN_W-1:0]     s_entry_index = '0;
    logic [ELT_W-1:0]        s_element_index = '0;
    logic signed [VAL_W-1:0] s_element_value = '0;
    logic                    s_enable_flag = 1'b0;
    logic                    s_last_element = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [STATUS_W-1:0]     m_status;
    logic [ENT_IN_W-1:0]     m_best_index;
    logic signed [VAL_W-1:0] m_score;
    logic [DIST_W-1:0]       m_distance_squared;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [DIM_W-1:0]        cfg_dim_in_use = '0;

    // predictor state
    bit signed [VAL_W-1:0] vec_mem [ENTRY_COUNT][512];
    bit                    entry_on [ENTRY_COUNT];
    bit signed [ACC_W-1:0] dot_acc [ENTRY_COUNT];
    bit [DIM_W-1:0]        query_count;
    logic [DIM_W-1:0]      dim_now = DIM_RESET;

    vec_beat_t      beat_q [$];
    search_report_t predicted_reports [$];
    vec_beat_t      drive_beat;
    search_report_t step_report;
    search_report_t want;
    int             idle_pct = 31;
    int             failures = 0;

    nearest_vector_search_engine_core u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_entry_index      (s_entry_index),
        .s_element_index    (s_element_index),
        .s_element_value    (s_element_value),
        .s_enable_flag      (s_enable_flag),
        .s_last_element     (s_last_element),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_best_index       (m_best_index),
        .m_score            (m_score),
        .m_distance_squared (m_distance_squared),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_dim_in_use     (cfg_dim_in_use)
    );

    always #1 aclk = ~aclk;

    function automatic bit nearest_search_step(input vec_beat_t b, output search_report_t r);
        int     i;
        int     best_i;
        bit     found;
        longint top;
        longint a;
        longint q;
        longint d;
        r = '0;
        found = 1'b0;
        top = 0;
        best_i = 0;
        case (b.kind)
            KIND_WRITE: begin
                vec_mem[b.entry_index][b.element_index] = b.element_value;
                return 1'b0;
            end
            KIND_ENABLE: begin
                entry_on[b.entry_index] = b.enable_flag;
                return 1'b0;
            end
            KIND_QUERY: begin
            end
            default: begin
                return 1'b0;
            end
        endcase
        if (b.element_index < dim_now) begin
            for (i = 0; i < ENTRY_COUNT; i++) begin
                dot_acc[i] += ACC_W'(longint'(b.element_value)
                                     * longint'(vec_mem[i][b.element_index]));
            end
        end
        if (query_count != COUNT_MAX) query_count++;
        if (!b.last_element) return 1'b0;

        if (query_count != dim_now) begin
            r.status = STATUS_MISMATCH;
        end else begin
            for (i = 0; i < ENTRY_COUNT; i++) begin
                a = dot_acc[i];
                if (entry_on[i] && (!found || a > top)) begin
                    found = 1'b1;
                    top = a;
                    best_i = i;
                end
            end
            if (!found) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.status = STATUS_MATCH;
                r.best_index = ENT_IN_W'(best_i);
                q = (top + 16384) >>> 15;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                r.score = VAL_W'(q);
                d = (longint'(1) << 31) - 2 * top;
                if (d <= 0) begin
                    d = 0;
                end else begin
                    d = (d + 16384) / 32768;
                    if (d > longint'(DIST_MAX)) d = longint'(DIST_MAX);
                end
                r.distance_squared = DIST_W'(d);
            end
        end
        for (i = 0; i < ENTRY_COUNT; i++) dot_acc[i] = '0;
        query_count = '0;
        return 1'b1;
    endfunction

    function automatic void push_beat(input logic [KIND_W-1:0] kind, input int ent,
                                      input int elt, input int val, input bit flag,
                                      input bit last);
        vec_beat_t b;
        b.kind = kind;
        b.entry_index = ENT_IN_W'(ent);
        b.element_index = ELT_W'(elt);
        b.element_value = VAL_W'(val);
        b.enable_flag = flag;
        b.last_element = last;
        beat_q.push_back(b);
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return -32768;
        if (r == 1) return 32767;
        if (r < 4) return int'($urandom_range(0, 6)) - 3;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int pick_read_elt();
        int e;
        do e = SAFE_ELTS[$urandom_range(0, 15)]; while (e >= dim_now);
        return e;
    endfunction

    function automatic void push_query(input int elt, input int val, input bit last);
        push_beat(KIND_QUERY, $urandom_range(0, 255), elt, val, $urandom_range(0, 1), last);
    endfunction

    function automatic void push_safe_write();
        push_beat(KIND_WRITE, $urandom_range(0, 255), SAFE_ELTS[$urandom_range(0, 15)],
                  pick_value(), $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    task automatic drain_and_settle();
        while (beat_q.size() != 0 || s_valid) @(posedge aclk);
        while (predicted_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_dim(input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_dim_in_use <= DIM_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dim_now = DIM_W'(value);
    endtask

    task automatic queue_random_traffic(input int budget);
        int made;
        int pick;
        int len;
        int k;
        bit drop_last;
        bit in_range;
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, dim_now + 2) : dim_now;
                drop_last = ($urandom_range(0, 19) == 0);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        push_safe_write();
                        made++;
                    end
                    in_range = dim_now >= 512 || dim_now <= 16
                               || $urandom_range(0, len - 1) < 6;
                    push_query(in_range ? pick_read_elt() : $urandom_range(dim_now, 511),
                               pick_value(), k == len - 1 && !drop_last);
                    made++;
                end
            end else if (pick < 75) begin
                push_safe_write();
                made++;
            end else if (pick < 80) begin
                push_beat(KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 511),
                          pick_value(), $urandom_range(0, 1), $urandom_range(0, 1));
                made++;
            end else if (pick < 95) begin
                push_beat(KIND_ENABLE, $urandom_range(0, 255), $urandom_range(0, 511),
                          pick_value(), $urandom_range(0, 9) < 7, $urandom_range(0, 1));
                made++;
            end else begin
                push_beat(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 511),
                          pick_value(), $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
    endtask

    task automatic compare_field(input string field, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
            failures++;
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (nearest_search_step(drive_beat, step_report))
                    predicted_reports.push_back(step_report);
            end
            if (!s_valid || s_ready) begin
                if (beat_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    drive_beat = beat_q.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= drive_beat.kind;
                    s_entry_index <= drive_beat.entry_index;
                    s_element_index <= drive_beat.element_index;
                    s_element_value <= drive_beat.element_value;
                    s_enable_flag <= drive_beat.enable_flag;
                    s_last_element <= drive_beat.last_element;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_reports.size() == 0) begin
                    $display("%0t: unexpected result beat, status %0d index %0d", $time,
                             m_status, m_best_index);
                    failures++;
                end else begin
                    want = predicted_reports.pop_front();
                    compare_field("status", want.status, m_status);
                    compare_field("best_index", want.best_index, m_best_index);
                    compare_field("score", want.score, m_score);
                    compare_field("distance_squared", want.distance_squared,
                                  m_distance_squared);
                end
            end
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial begin
        int e;
        int s;
        int p;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // define the readable elements of every entry; small values on 0 and 1 give ties
        for (e = 0; e < ENTRY_COUNT; e++) begin
            for (s = 0; s < 16; s++) begin
                push_beat(KIND_WRITE, e, SAFE_ELTS[s],
                          (s < 2) ? int'($urandom_range(0, 6)) - 3 : pick_value(), 1'b0, 1'b0);
            end
        end

        // short query on an empty table: length check wins
        push_query(0, 32767, 1'b1);
        drain_and_settle();
        write_dim(1);
        push_query(0, -32768, 1'b1);
        drain_and_settle();

        write_dim(2);
        push_beat(KIND_WRITE, 3, 0, 32767, 1'b0, 1'b0);
        push_beat(KIND_WRITE, 3, 1, 32767, 1'b0, 1'b0);
        push_beat(KIND_WRITE, 9, 0, 32767, 1'b0, 1'b0);
        push_beat(KIND_WRITE, 9, 1, 32767, 1'b0, 1'b0);
        push_beat(KIND_ENABLE, 3, 0, 0, 1'b1, 1'b0);
        push_beat(KIND_ENABLE, 9, 0, 0, 1'b1, 1'b0);
        push_query(0, 32767, 1'b0);
        push_query(1, 32767, 1'b1);
        push_beat(KIND_WRITE, 9, 1, -32768, 1'b0, 1'b0);
        push_query(0, -32768, 1'b0);
        push_query(1, 32767, 1'b1);
        push_beat(KIND_ENABLE, 3, 0, 0, 1'b0, 1'b0);
        push_query(0, -32768, 1'b0);
        push_query(1, 32767, 1'b1);
        push_beat(KIND_UNUSED, 255, 511, -1, 1'b1, 1'b1);
        push_beat(KIND_ENABLE, 255, 511, -1, 1'b1, 1'b1);
        push_query(300, 1234, 1'b0);
        push_query(0, 100, 1'b1);
        drain_and_settle();

        // full-length query whose sum wraps the accumulator
        write_dim(512);
        push_beat(KIND_WRITE, 5, 0, -32768, 1'b0, 1'b0);
        push_beat(KIND_ENABLE, 9, 0, 0, 1'b0, 1'b0);
        push_beat(KIND_ENABLE, 255, 0, 0, 1'b0, 1'b0);
        push_beat(KIND_ENABLE, 5, 0, 0, 1'b1, 1'b0);
        for (e = 0; e < 512; e++) push_query(0, -32768, e == 511);
        drain_and_settle();

        // element count saturation
        write_dim(1);
        for (e = 0; e < OVERFLOW_LEN; e++)
            push_query($urandom_range(1, 511), pick_value(), e == OVERFLOW_LEN - 1);
        drain_and_settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_dim((p == RANDOM_PHASES - 1) ? $urandom_range(17, 300) : PHASE_DIMS[p]);
            idle_pct = (p == 3) ? 0 : 31;
            queue_random_traffic(PHASE_BEATS);
            drain_and_settle();
        end

        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
